@@ hdl/ptat_pkg.sv @@
// Shared types, widths and helpers for the pan/tilt aim tracker.
// Used by ptat_axis_lane, ptat_merge and pan_tilt_aim_tracker; no dependencies.
package ptat_pkg;

  // Field and register widths.
  localparam int ANGLE_W         = 13;
  localparam int LIMIT_W         = 12;
  localparam int THR_W           = 10;
  localparam int RATE_W          = 8;
  localparam int MS_W            = 16;
  localparam int DUR_W           = 17;
  localparam int TIME_W          = 32;
  localparam int REQ_W           = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 16;

  // Angles carry this many fraction bits (1/16 degree).
  localparam int ANGLE_FRAC_BITS = 4;

  // Angle differences span twice the angle range.
  localparam int DIFF_W          = ANGLE_W + 1;
  localparam int PROD_W          = RATE_W + DIFF_W;
  localparam int SCALED_W        = PROD_W - ANGLE_FRAC_BITS;

  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  // Register reset values.
  localparam logic [LIMIT_W-1:0] PAN_LIMIT_RST    = LIMIT_W'(1440);
  localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST   = LIMIT_W'(240);
  localparam logic [THR_W-1:0]   AIM_THRESH_RST   = THR_W'(24);
  localparam logic [RATE_W-1:0]  PAN_RATE_RST     = RATE_W'(16);
  localparam logic [RATE_W-1:0]  TILT_RATE_RST    = RATE_W'(16);
  localparam logic [MS_W-1:0]    MIN_MOVE_RST     = MS_W'(75);
  localparam logic [MS_W-1:0]    CHECK_INTV_RST   = MS_W'(200);

  // Request codes of the input word.
  typedef enum logic [REQ_W-1:0] {
    REQ_SET_PAN  = 2'd0,
    REQ_SET_TILT = 2'd1,
    REQ_UPDATE   = 2'd2
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PAN_LIMIT   = 3'd0,
    CFG_TILT_LIMIT  = 3'd1,
    CFG_AIM_THRESH  = 3'd2,
    CFG_PAN_RATE    = 3'd3,
    CFG_TILT_RATE   = 3'd4,
    CFG_MIN_MOVE    = 3'd5,
    CFG_CHECK_INTV  = 3'd6
  } cfg_idx_e;

  // Control from the merge stage to one axis lane.
  typedef struct packed {
    logic set_req;   // store a new clamped target
    logic latch;     // take the servo reading
    logic commit;    // commanded angle follows the target
  } lane_ctrl_t;

  // Status from one axis lane to the merge stage.
  typedef struct packed {
    logic                      changed;
    logic signed [ANGLE_W-1:0] target;
    logic [DUR_W-1:0]          dur;
    logic                      reached;
  } lane_stat_t;

  // Magnitude of the difference of two angles.
  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [ANGLE_W-1:0] a,
                                                 input logic signed [ANGLE_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

@@ hdl/ptat_axis_lane.sv @@
// One axis of the tracker: target, commanded and latched angles, move duration.
// Depends on ptat_pkg; instantiated once for pan and once for tilt.
module ptat_axis_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ptat_pkg::lane_ctrl_t                ctrl_i,
  input  logic signed [ptat_pkg::ANGLE_W-1:0] angle_i,
  input  logic signed [ptat_pkg::ANGLE_W-1:0] reading_i,
  input  logic [ptat_pkg::LIMIT_W-1:0]        limit_i,
  input  logic [ptat_pkg::RATE_W-1:0]         rate_i,
  input  logic [ptat_pkg::THR_W-1:0]          thresh_i,
  input  logic [ptat_pkg::MS_W-1:0]           min_ms_i,
  output ptat_pkg::lane_stat_t                stat_o
);
  import ptat_pkg::*;

  logic signed [ANGLE_W-1:0] requested_q, commanded_q, latched_q;
  logic signed [ANGLE_W-1:0] requested_d, commanded_d, latched_d;
  logic signed [ANGLE_W-1:0] lim_pos, lim_neg, clamped;
  logic [DIFF_W-1:0]         mv_abs, ck_abs;
  logic [PROD_W-1:0]         prod;
  logic [SCALED_W-1:0]       scaled, floored;
  logic [DUR_W-1:0]          dur;

  // Clamp the requested angle to the signed limit.
  always_comb begin
    lim_pos = $signed({1'b0, limit_i});
    lim_neg = -lim_pos;
    if (angle_i > lim_pos) begin
      clamped = lim_pos;
    end else if (angle_i < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = angle_i;
    end
  end

  // The reading taken in this cycle is already used for duration and check.
  assign latched_d   = ctrl_i.latch   ? reading_i   : latched_q;
  assign requested_d = ctrl_i.set_req ? clamped     : requested_q;
  assign commanded_d = ctrl_i.commit  ? requested_q : commanded_q;

  // Move duration: rate times travel, scaled to degrees, floored and saturated.
  always_comb begin
    mv_abs  = abs_diff(latched_d, requested_q);
    prod    = PROD_W'(rate_i) * PROD_W'(mv_abs);
    scaled  = prod[PROD_W-1:ANGLE_FRAC_BITS];
    floored = (scaled < SCALED_W'(min_ms_i)) ? SCALED_W'(min_ms_i) : scaled;
    dur     = (floored > SCALED_W'(DUR_MAX)) ? DUR_MAX : floored[DUR_W-1:0];
  end

  // Position-reached test against the commanded angle.
  assign ck_abs = abs_diff(latched_d, commanded_q);

  always_comb begin
    stat_o.changed = (commanded_q != requested_q);
    stat_o.target  = requested_q;
    stat_o.dur     = dur;
    stat_o.reached = (ck_abs < DIFF_W'(thresh_i));
  end

  // Axis state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      requested_q <= '0;
      commanded_q <= '0;
      latched_q   <= '0;
    end else begin
      requested_q <= requested_d;
      commanded_q <= commanded_d;
      latched_q   <= latched_d;
    end
  end

endmodule

@@ hdl/ptat_merge.sv @@
// Merge stage: decides move or check for each word, drives the lanes, keeps the
// aimed flag and check time, and holds the output register. Depends on ptat_pkg.
module ptat_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ptat_pkg::REQ_W-1:0]          req_type_i,
  input  logic [ptat_pkg::TIME_W-1:0]         now_ms_i,
  input  logic                                pan_reading_ok_i,
  input  logic                                tilt_reading_ok_i,
  input  logic [ptat_pkg::MS_W-1:0]           check_interval_i,
  input  ptat_pkg::lane_stat_t                pan_stat_i,
  input  ptat_pkg::lane_stat_t                tilt_stat_i,
  output ptat_pkg::lane_ctrl_t                pan_ctrl_o,
  output ptat_pkg::lane_ctrl_t                tilt_ctrl_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                pan_move_o,
  output logic signed [ptat_pkg::ANGLE_W-1:0] pan_move_angle_o,
  output logic [ptat_pkg::DUR_W-1:0]          pan_move_ms_o,
  output logic                                tilt_move_o,
  output logic signed [ptat_pkg::ANGLE_W-1:0] tilt_move_angle_o,
  output logic [ptat_pkg::DUR_W-1:0]          tilt_move_ms_o,
  output logic                                new_target_o,
  output logic                                aimed_o
);
  import ptat_pkg::*;

  logic                accept;
  logic                set_pan, set_tilt, is_upd;
  logic                any_chg, mv, chk, rd;
  logic [TIME_W-1:0]   due;
  logic                aimed_q, aimed_d;
  logic [TIME_W-1:0]   last_chk_q, last_chk_d;
  logic                out_valid_q, out_valid_d;

  logic                      pan_move_q, tilt_move_q, new_target_q, aimed_out_q;
  logic signed [ANGLE_W-1:0] pan_ang_q, tilt_ang_q;
  logic [DUR_W-1:0]          pan_ms_q, tilt_ms_q;

  // A new word enters whenever the output register is empty or drains.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the request.
  always_comb begin
    set_pan  = 1'b0;
    set_tilt = 1'b0;
    is_upd   = 1'b0;
    case (req_type_i)
      REQ_SET_PAN:  set_pan  = 1'b1;
      REQ_SET_TILT: set_tilt = 1'b1;
      REQ_UPDATE:   is_upd   = 1'b1;
      default: ;
    endcase
  end

  // Move when a target changed; otherwise check, unless aimed, after the interval.
  assign any_chg = pan_stat_i.changed || tilt_stat_i.changed;
  assign due     = last_chk_q + TIME_W'(check_interval_i);
  assign mv      = is_upd && any_chg;
  assign chk     = is_upd && !any_chg && !aimed_q && (now_ms_i > due);
  assign rd      = mv || chk;

  // Lane controls; tilt is read only behind a valid pan reading.
  always_comb begin
    pan_ctrl_o.set_req  = accept && set_pan;
    pan_ctrl_o.latch    = accept && rd && pan_reading_ok_i;
    pan_ctrl_o.commit   = accept && mv && pan_stat_i.changed;
    tilt_ctrl_o.set_req = accept && set_tilt;
    tilt_ctrl_o.latch   = accept && rd && pan_reading_ok_i && tilt_reading_ok_i;
    tilt_ctrl_o.commit  = accept && mv && tilt_stat_i.changed;
  end

  // Aimed flag and check time.
  always_comb begin
    aimed_d    = aimed_q;
    last_chk_d = last_chk_q;
    if (accept && mv) begin
      aimed_d = 1'b0;
    end else if (accept && chk) begin
      last_chk_d = now_ms_i;
      if (pan_reading_ok_i && tilt_reading_ok_i &&
          pan_stat_i.reached && tilt_stat_i.reached) begin
        aimed_d = 1'b1;
      end
    end
  end

  assign out_valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aimed_q     <= 1'b0;
      last_chk_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      aimed_q     <= aimed_d;
      last_chk_q  <= last_chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register, loaded with each accepted word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pan_move_q   <= mv && pan_stat_i.changed;
      pan_ang_q    <= (mv && pan_stat_i.changed) ? pan_stat_i.target : '0;
      pan_ms_q     <= (mv && pan_stat_i.changed) ? pan_stat_i.dur : '0;
      tilt_move_q  <= mv && tilt_stat_i.changed;
      tilt_ang_q   <= (mv && tilt_stat_i.changed) ? tilt_stat_i.target : '0;
      tilt_ms_q    <= (mv && tilt_stat_i.changed) ? tilt_stat_i.dur : '0;
      new_target_q <= mv;
      aimed_out_q  <= aimed_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pan_move_o        = pan_move_q;
  assign pan_move_angle_o  = pan_ang_q;
  assign pan_move_ms_o     = pan_ms_q;
  assign tilt_move_o       = tilt_move_q;
  assign tilt_move_angle_o = tilt_ang_q;
  assign tilt_move_ms_o    = tilt_ms_q;
  assign new_target_o      = new_target_q;
  assign aimed_o           = aimed_out_q;

endmodule

@@ hdl/pan_tilt_aim_tracker.sv @@
// Top level of the pan/tilt aim tracker: configuration registers, two axis
// lanes and the merge stage. Depends on ptat_pkg, ptat_axis_lane, ptat_merge.
//
// Usage: input words arrive on in_valid_i/in_ready_o carrying a request type
// (set pan target, set tilt target, update tick), an angle, the millisecond
// time and both servo readings. Every accepted word yields exactly one result
// word on out_valid_o/out_ready_i with the move commands, the new-target flag
// and the aimed flag. One word is taken per cycle while in_ready_o is high:
// both axis lanes compute clamp, travel, duration and reached test in the
// cycle of acceptance, and the merge stage registers the result. When the
// receiver stalls, the result stays in the output register and in_ready_o
// drops until it is taken; a word is still accepted in the same cycle that
// the held result leaves. Reset clears the lane angles, the aimed flag and
// the check time and loads the register defaults. Configuration is a plain
// write port (cfg_we_i, cfg_addr_i, cfg_wdata_i), to be written only while
// idle; the user must keep to this, the block does not enforce it.
module pan_tilt_aim_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ptat_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [ptat_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ptat_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [ptat_pkg::ANGLE_W-1:0] angle_i,
  input  logic [ptat_pkg::TIME_W-1:0]         now_ms_i,
  input  logic signed [ptat_pkg::ANGLE_W-1:0] pan_reading_i,
  input  logic                                pan_reading_ok_i,
  input  logic signed [ptat_pkg::ANGLE_W-1:0] tilt_reading_i,
  input  logic                                tilt_reading_ok_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                pan_move_o,
  output logic signed [ptat_pkg::ANGLE_W-1:0] pan_move_angle_o,
  output logic [ptat_pkg::DUR_W-1:0]          pan_move_ms_o,
  output logic                                tilt_move_o,
  output logic signed [ptat_pkg::ANGLE_W-1:0] tilt_move_angle_o,
  output logic [ptat_pkg::DUR_W-1:0]          tilt_move_ms_o,
  output logic                                new_target_o,
  output logic                                aimed_o
);
  import ptat_pkg::*;

  logic [LIMIT_W-1:0] pan_limit_q, tilt_limit_q;
  logic [THR_W-1:0]   aim_thresh_q;
  logic [RATE_W-1:0]  pan_rate_q, tilt_rate_q;
  logic [MS_W-1:0]    min_move_q, check_intv_q;

  lane_ctrl_t pan_ctrl, tilt_ctrl;
  lane_stat_t pan_stat, tilt_stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_limit_q  <= PAN_LIMIT_RST;
      tilt_limit_q <= TILT_LIMIT_RST;
      aim_thresh_q <= AIM_THRESH_RST;
      pan_rate_q   <= PAN_RATE_RST;
      tilt_rate_q  <= TILT_RATE_RST;
      min_move_q   <= MIN_MOVE_RST;
      check_intv_q <= CHECK_INTV_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PAN_LIMIT:  pan_limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_TILT_LIMIT: tilt_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_AIM_THRESH: aim_thresh_q <= cfg_wdata_i[THR_W-1:0];
        CFG_PAN_RATE:   pan_rate_q   <= cfg_wdata_i[RATE_W-1:0];
        CFG_TILT_RATE:  tilt_rate_q  <= cfg_wdata_i[RATE_W-1:0];
        CFG_MIN_MOVE:   min_move_q   <= cfg_wdata_i[MS_W-1:0];
        CFG_CHECK_INTV: check_intv_q <= cfg_wdata_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pan lane.
  ptat_axis_lane u_pan_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pan_ctrl),
    .angle_i   (angle_i),
    .reading_i (pan_reading_i),
    .limit_i   (pan_limit_q),
    .rate_i    (pan_rate_q),
    .thresh_i  (aim_thresh_q),
    .min_ms_i  (min_move_q),
    .stat_o    (pan_stat)
  );

  // Tilt lane.
  ptat_axis_lane u_tilt_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tilt_ctrl),
    .angle_i   (angle_i),
    .reading_i (tilt_reading_i),
    .limit_i   (tilt_limit_q),
    .rate_i    (tilt_rate_q),
    .thresh_i  (aim_thresh_q),
    .min_ms_i  (min_move_q),
    .stat_o    (tilt_stat)
  );

  // Decision, aimed flag and output register.
  ptat_merge u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .now_ms_i          (now_ms_i),
    .pan_reading_ok_i  (pan_reading_ok_i),
    .tilt_reading_ok_i (tilt_reading_ok_i),
    .check_interval_i  (check_intv_q),
    .pan_stat_i        (pan_stat),
    .tilt_stat_i       (tilt_stat),
    .pan_ctrl_o        (pan_ctrl),
    .tilt_ctrl_o       (tilt_ctrl),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pan_move_o        (pan_move_o),
    .pan_move_angle_o  (pan_move_angle_o),
    .pan_move_ms_o     (pan_move_ms_o),
    .tilt_move_o       (tilt_move_o),
    .tilt_move_angle_o (tilt_move_angle_o),
    .tilt_move_ms_o    (tilt_move_ms_o),
    .new_target_o      (new_target_o),
    .aimed_o           (aimed_o)
  );

endmodule
